// ===== hw/rtl/fbr_pkg.sv =====
package fbr_pkg;

    localparam int ADDR_W = 28;
    localparam int WADDR_W = 32;
    localparam int RES_W = 12;
    localparam int LEN_W = 2 * RES_W + 1;
    localparam int IDX_OUT_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W = 3;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 7;

    localparam int DEF_BUFFER_COUNT = 4;
    localparam int DEF_BUFFER_BASE = 32'h0100_0000;
    localparam int DEF_BUFFER_BYTES = 1920 * 1080 * 2;

    localparam logic [63:0] ADDR_MASK = 64'h0fff_ffff;

    // register select, taken from paddr[2]
    localparam logic REG_HRES = 1'b0;
    localparam logic REG_VRES = 1'b1;

    typedef struct packed {
        logic [RES_W-1:0] hres;
        logic [RES_W-1:0] vres;
        logic [LEN_W-1:0] exp_len;
    } fbr_cfg_t;

    typedef struct packed {
        logic               pending0;
        logic [WADDR_W-1:0] addr0;
        logic               pending1;
        logic [WADDR_W-1:0] addr1;
        logic [RES_W-1:0]   hres;
        logic [RES_W-1:0]   vres;
    } fbr_item_t;

    typedef struct packed {
        logic                 rearm0;
        logic [ADDR_W-1:0]    base0;
        logic                 rearm1;
        logic [ADDR_W-1:0]    base1;
        logic                 stray0;
        logic                 stray1;
        logic                 bad0;
        logic                 bad1;
        logic                 mismatch;
        logic [IDX_OUT_W-1:0] shown;
    } fbr_result_t;

endpackage

// ===== hw/rtl/fbr_regs.sv =====
module fbr_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbr_pkg::PADDR_W-1:0]         paddr,
    input  logic [fbr_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [fbr_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output fbr_pkg::fbr_cfg_t                   cfg
);
    import fbr_pkg::*;

    logic [RES_W-1:0]   hres_reg, hres_next;
    logic [RES_W-1:0]   vres_reg, vres_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [2*RES_W-1:0] prod;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        hres_next = hres_reg;
        vres_next = vres_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_HRES: hres_next = pwdata[RES_W-1:0];
                REG_VRES: vres_next = pwdata[RES_W-1:0];
                default:  ;
            endcase
        end
    end

    // frame size in bytes, two bytes per pixel
    assign prod     = hres_reg * vres_reg;
    assign len_next = {prod, 1'b0};

    always_comb begin
        unique case (paddr[2])
            REG_HRES: prdata = {{(CFG_DATA_W-RES_W){1'b0}}, hres_reg};
            REG_VRES: prdata = {{(CFG_DATA_W-RES_W){1'b0}}, vres_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hres_reg <= '0;
            vres_reg <= '0;
            len_reg  <= '0;
        end else begin
            hres_reg <= hres_next;
            vres_reg <= vres_next;
            len_reg  <= len_next;
        end
    end

    assign cfg.hres    = hres_reg;
    assign cfg.vres    = vres_reg;
    assign cfg.exp_len = len_reg;

endmodule

// ===== hw/rtl/fbr_ring.sv =====
module fbr_ring #(
    parameter int BUFFER_COUNT = fbr_pkg::DEF_BUFFER_COUNT,
    parameter int BUFFER_BASE  = fbr_pkg::DEF_BUFFER_BASE,
    parameter int BUFFER_BYTES = fbr_pkg::DEF_BUFFER_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  fbr_pkg::fbr_item_t   item,
    input  fbr_pkg::fbr_cfg_t    cfg,
    output fbr_pkg::fbr_result_t result
);
    import fbr_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_COUNT);
    localparam logic [63:0] STRAY_LO = 64'(BUFFER_BASE) & ADDR_MASK;
    localparam logic [63:0] STRAY_HI = STRAY_LO + 64'(BUFFER_BYTES) * 64'(BUFFER_COUNT);

    logic [IDX_W-1:0]  slot0_buf_reg, slot0_buf_next;
    logic [IDX_W-1:0]  slot1_buf_reg, slot1_buf_next;
    logic [IDX_W-1:0]  next_buf_reg, next_buf_next;
    logic [IDX_W-1:0]  shown_buf_reg, shown_buf_next;
    logic [IDX_W-1:0]  next_mid, shown_mid;
    logic [ADDR_W-1:0] base_tab [BUFFER_COUNT];
    logic [WADDR_W-1:0] len0, len1, exp_len;
    logic              mism, hit0, hit1;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(BUFFER_COUNT - 1)) begin
            r = '0;
        end else begin
            r = idx + IDX_W'(1);
        end
        return r;
    endfunction

    for (genvar i = 0; i < BUFFER_COUNT; i++) begin : g_base
        assign base_tab[i] = ADDR_W'((64'(BUFFER_BASE) + 64'(i) * 64'(BUFFER_BYTES))
                                     & ADDR_MASK);
    end

    assign exp_len = {{(WADDR_W-LEN_W){1'b0}}, cfg.exp_len};
    assign mism    = (item.hres != cfg.hres) || (item.vres != cfg.vres);

    // slot 0 first, slot 1 sees the ring as slot 0 left it
    assign len0 = item.addr0 - {{(WADDR_W-ADDR_W){1'b0}}, base_tab[slot0_buf_reg]};
    assign hit0 = item.pending0 && !mism && (len0 == exp_len);
    assign slot0_buf_next = hit0 ? next_buf_reg : slot0_buf_reg;
    assign next_mid       = hit0 ? ring_inc(next_buf_reg) : next_buf_reg;
    assign shown_mid      = hit0 ? slot0_buf_reg : shown_buf_reg;

    assign len1 = item.addr1 - {{(WADDR_W-ADDR_W){1'b0}}, base_tab[slot1_buf_reg]};
    assign hit1 = item.pending1 && !mism && (len1 == exp_len);
    assign slot1_buf_next = hit1 ? next_mid : slot1_buf_reg;
    assign next_buf_next  = hit1 ? ring_inc(next_mid) : next_mid;
    assign shown_buf_next = hit1 ? slot1_buf_reg : shown_mid;

    always_comb begin
        result.rearm0   = item.pending0;
        result.base0    = item.pending0 ? base_tab[slot0_buf_next] : '0;
        result.rearm1   = item.pending1;
        result.base1    = item.pending1 ? base_tab[slot1_buf_next] : '0;
        result.stray0   = item.pending0 && (({32'b0, item.addr0} < STRAY_LO) ||
                                            ({32'b0, item.addr0} > STRAY_HI));
        result.stray1   = item.pending1 && (({32'b0, item.addr1} < STRAY_LO) ||
                                            ({32'b0, item.addr1} > STRAY_HI));
        result.bad0     = item.pending0 && !mism && !hit0;
        result.bad1     = item.pending1 && !mism && !hit1;
        result.mismatch = mism;
        result.shown    = shown_buf_next[IDX_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot0_buf_reg <= IDX_W'(0);
            slot1_buf_reg <= IDX_W'(1);
            next_buf_reg  <= IDX_W'(2);
            shown_buf_reg <= IDX_W'(3);
        end else if (step) begin
            slot0_buf_reg <= slot0_buf_next;
            slot1_buf_reg <= slot1_buf_next;
            next_buf_reg  <= next_buf_next;
            shown_buf_reg <= shown_buf_next;
        end
    end

endmodule

// ===== hw/rtl/dma_frame_buffer_rotation.sv =====
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata, s_tuser: one frame-done event
// m_       | out | m_tvalid/m_tready  | m_tdata, m_tuser: slot re-arm result
// apb      | in  | psel/penable       | expected_hres @0x0, expected_vres @0x4
//
// One item per cycle while m_ does not stall, through an input register, then
// ring update and compares into the result register.
// Ring state moves when an item passes from the input to the result register.
// Synchronous active-low reset clears ring state and the valid flags; item and result registers are not reset.
// A stall on m_ holds the result; s_tready drops only when both stages are full.
module dma_frame_buffer_rotation #(
    parameter int BUFFER_COUNT = fbr_pkg::DEF_BUFFER_COUNT,
    parameter int BUFFER_BASE  = fbr_pkg::DEF_BUFFER_BASE,
    parameter int BUFFER_BYTES = fbr_pkg::DEF_BUFFER_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // slot0_end_address, slot1_end_address, detected_hres, detected_vres
    input  logic [fbr_pkg::S_TDATA_W-1:0]    s_tdata,
    // slot0_pending, slot1_pending
    input  logic [fbr_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot0_base, slot1_base, shown_index, zero pad
    output logic [fbr_pkg::M_TDATA_W-1:0]    m_tdata,
    // slot0_rearm, slot1_rearm, slot0_stray, slot1_stray,
    // slot0_bad_length, slot1_bad_length, resolution_mismatch
    output logic [fbr_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbr_pkg::PADDR_W-1:0]      paddr,
    input  logic [fbr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [fbr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import fbr_pkg::*;

    fbr_cfg_t    cfg;
    fbr_item_t   s_item;
    fbr_item_t   in_item_reg;
    fbr_result_t ring_res;
    fbr_result_t out_res_reg;
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        advance, step, s_accept;

    fbr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbr_ring #(
        .BUFFER_COUNT (BUFFER_COUNT),
        .BUFFER_BASE  (BUFFER_BASE),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (ring_res)
    );

    assign s_item.pending0 = s_tuser[0];
    assign s_item.addr0    = s_tdata[31:0];
    assign s_item.pending1 = s_tuser[1];
    assign s_item.addr1    = s_tdata[63:32];
    assign s_item.hres     = s_tdata[75:64];
    assign s_item.vres     = s_tdata[87:76];

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_res_reg <= ring_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*ADDR_W-IDX_OUT_W){1'b0}}, out_res_reg.shown,
                       out_res_reg.base1, out_res_reg.base0};
    assign m_tuser  = {out_res_reg.mismatch, out_res_reg.bad1, out_res_reg.bad0,
                       out_res_reg.stray1, out_res_reg.stray0,
                       out_res_reg.rearm1, out_res_reg.rearm0};

    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("item lost between input and result register");

    a_mismatch_no_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.mismatch |-> !out_res_reg.bad0 && !out_res_reg.bad1)
        else $error("length flagged on a dropped frame");

    a_base_only_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg.rearm0 || out_res_reg.base0 == '0) &&
                          (out_res_reg.rearm1 || out_res_reg.base1 == '0))
        else $error("base given for a slot not re-armed");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule
